>>> rtl/slp_pkg.sv
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types and constants of the sample loop playback engine.
// ----------------------------------------------------------------------------
package slp_pkg;

  localparam int unsigned MEM_AW    = 17;
  localparam int unsigned MEM_DEPTH = 131072;
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned POS_W     = 25;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned DIV_NW    = 32;
  localparam int unsigned DIV_DW    = 16;

  // ceil(2^31 / 255): x * RECIP_255 >> 31 equals x / 255 for any x below 2^24.
  localparam logic [23:0] RECIP_255 = 24'd8421505;

  typedef enum logic [1:0] {
    ACT_STORE   = 2'd0,
    ACT_PLAY    = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_LOOP_START   = 3'd0,
    REG_LOOP_END     = 3'd1,
    REG_TRIM_START   = 3'd2,
    REG_TRIM_END     = 3'd3,
    REG_REL_MARGIN   = 3'd4,
    REG_SAMPLE_LEN   = 3'd5,
    REG_LOOP_RAMP    = 3'd6,
    REG_FORMAT       = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PLAN,
    S_DPP,
    S_DRM,
    S_DLL,
    S_XF,
    S_DW,
    S_RA,
    S_RD,
    S_MIX,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

endpackage

>>> rtl/slp_ram.sv
// ----------------------------------------------------------------------------
// slp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module slp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/slp_div.sv
// ----------------------------------------------------------------------------
// slp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slp_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slp_pkg::div_req_t    req,
  output slp_pkg::div_rsp_t    rsp
);
  import slp_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic [DIV_NW-1:0]   quo_r, quo_nxt;
  logic [DIV_DW-1:0]   rem_r, rem_nxt;
  logic [DIV_DW-1:0]   den_r, den_nxt;
  logic [DIV_DW:0]     trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, quo_r[DIV_NW-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DIV_DW'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_DW-1:0];
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(DIV_NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

>>> rtl/sample_loop_playback.sv
// Sample loop playback engine, one item at a time; the input stalls while an item is in work.
// A ping-pong or forward wrap adds one divider pass; a crossfade adds one more pass plus
// extra reads and mixing. A stalled result holds the engine in its last state. Synchronous
// active-low reset restores the register defaults and clears the release latch; the sample
// memory is not cleared.
// ----------------------------------------------------------------------------
// sample_loop_playback
// Top level: configuration registers, play sequencer, sample memory and mixer.
// ----------------------------------------------------------------------------
module sample_loop_playback #(
  parameter int unsigned MAX_FRAMES  = 65536,
  parameter int unsigned RAMP_WINDOW = 480
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [slp_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic [16:0]                 in_sample_address,
  input  logic signed [15:0]          in_sample_value,
  input  logic [23:0]                 in_pitched_position,
  input  logic [31:0]                 in_step_count,
  input  logic [15:0]                 in_position_offset,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [15:0]          out_left_out,
  output logic signed [15:0]          out_right_out,
  output logic                        out_release_triggered,
  output logic [31:0]                 out_release_step
);
  import slp_pkg::*;

  localparam logic [16:0] RW2  = 17'(2 * RAMP_WINDOW);
  localparam logic [15:0] RW16 = 16'(RAMP_WINDOW);
  localparam logic [25:0] MAXF = 26'(MAX_FRAMES);

  // Configuration registers.
  logic [15:0] loop_start_r, loop_end_r, trim_start_r, trim_end_r, margin_r;
  logic [16:0] slen_r;
  logic [7:0]  ramp_r;
  logic [5:0]  format_r;

  state_t      state_r, state_nxt;
  logic        rel_valid_r;
  logic [31:0] rel_step_r, step_r;
  logic [POS_W-1:0] p_r;
  logic [15:0] rm_r, ll_r;
  logic [23:0] rmn_r;
  logic [16:0] w_r;
  logic        do_read_r, do_mix_r, check_r;
  logic [1:0]  idx_r;
  logic        oor_r;
  logic [15:0] word_r [4];
  logic [2:0]  k_r;
  logic signed [35:0] prod_r, accl_r, accr_r;
  logic        out_valid_r;
  logic [15:0] out_l_r, out_r_r;
  logic        out_rel_r;
  logic [31:0] out_step_r;

  div_req_t    dreq;
  div_rsp_t    drsp;

  logic        accept;
  logic [15:0] len;
  logic [15:0] ll_new;
  logic [23:0] rm_num;
  logic [47:0] rm_prod;
  logic [15:0] rm_calc;
  logic        p_gt_le;
  logic        xf_hit;
  logic [POS_W-1:0] xf_d;
  logic [POS_W-1:0] frame;
  logic [25:0] addr26;
  logic        ram_we;
  logic [16:0] ram_raddr;
  logic [15:0] ram_rdata;
  logic [15:0] qmask;
  logic        fin_go;
  logic        rel_fire;
  logic signed [16:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [35:0] sum_l, sum_r;
  logic [15:0] mix_l, mix_r;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign fin_go   = !out_valid_r || !out_stall;

  assign len     = loop_end_r - loop_start_r;
  // Ramp numerator over 255; the short-loop case is halved first to divide by 510.
  assign rm_num  = ({1'b0, len} >= RW2) ? 24'(RW16) * 24'(ramp_r)
                                        : 24'((24'(len) * 24'(ramp_r)) >> 1);
  assign rm_prod = 48'(rmn_r) * 48'(RECIP_255);
  assign rm_calc = rm_prod[46:31];
  assign ll_new  = len - rm_calc;
  assign p_gt_le = p_r > POS_W'(loop_end_r);
  assign xf_hit  = (rm_r != '0) && (p_r > POS_W'(loop_end_r - rm_r));
  assign xf_d    = p_r - POS_W'(loop_end_r) + POS_W'(rm_r);

  // Quantize by clearing the low (15 - depth) bits.
  assign qmask = 16'hFFFF << (4'd15 - format_r[5:2]);

  // Read address: the crossfade partner frame sits one loop length earlier.
  assign frame  = idx_r[1] ? p_r - POS_W'(ll_r) : p_r;
  assign addr26 = format_r[0] ? {frame, idx_r[0]} : {1'b0, frame};
  assign ram_raddr = addr26[16:0];
  assign ram_we    = accept && (in_action == ACT_STORE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) begin
        state_nxt = (in_action == ACT_PLAY) ? S_PLAN : S_FIN;
      end
      S_PLAN: begin
        if (loop_end_r == '0) begin
          state_nxt = (loop_start_r == '0 && p_r < POS_W'(slen_r)) ? S_RA : S_FIN;
        end else if (loop_start_r >= loop_end_r) begin
          state_nxt = p_gt_le ? S_FIN : S_RA;
        end else if (format_r[1]) begin
          state_nxt = p_gt_le ? S_DPP : S_RA;
        end else begin
          state_nxt = S_DRM;
        end
      end
      S_DPP: if (drsp.done) state_nxt = S_RA;
      S_DRM: state_nxt = p_gt_le ? S_DLL : S_XF;
      S_DLL: if (drsp.done) state_nxt = S_XF;
      S_XF:  state_nxt = xf_hit ? S_DW : S_RA;
      S_DW:  if (drsp.done) state_nxt = S_RA;
      S_RA:  state_nxt = S_RD;
      S_RD: begin
        if (idx_r == {do_mix_r, 1'b1}) state_nxt = do_mix_r ? S_MIX : S_FIN;
        else state_nxt = S_RA;
      end
      S_MIX: if (k_r == 3'd4) state_nxt = S_FIN;
      S_FIN: if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Divider requests.
  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = '0;
    case (state_r)
      S_PLAN: begin
        if (loop_end_r != '0 && loop_start_r < loop_end_r && format_r[1]) begin
          dreq.start = p_gt_le;
          dreq.num   = DIV_NW'(p_r - POS_W'(loop_end_r));
          dreq.den   = len;
        end
      end
      S_DRM: begin
        dreq.start = p_gt_le;
        dreq.num   = DIV_NW'(p_r - POS_W'(loop_end_r));
        dreq.den   = ll_new;
      end
      S_XF: begin
        dreq.start = xf_hit;
        dreq.num   = {xf_d[15:0], 16'h0000};
        dreq.den   = rm_r;
      end
      default: dreq.start = 1'b0;
    endcase
  end

  // Shared multiplier operands: left pair, then right pair.
  always_comb begin
    case (k_r)
      3'd0: begin
        mul_a = 17'(signed'(word_r[0]));
        mul_b = 18'sd65536 - signed'({1'b0, w_r});
      end
      3'd1: begin
        mul_a = 17'(signed'(word_r[2]));
        mul_b = signed'({1'b0, w_r});
      end
      3'd2: begin
        mul_a = 17'(signed'(word_r[1]));
        mul_b = 18'sd65536 - signed'({1'b0, w_r});
      end
      default: begin
        mul_a = 17'(signed'(word_r[3]));
        mul_b = signed'({1'b0, w_r});
      end
    endcase
  end

  // Truncate toward zero on the divide by 65536.
  assign sum_l = accl_r + (accl_r[35] ? 36'sd65535 : 36'sd0);
  assign sum_r = accr_r + (accr_r[35] ? 36'sd65535 : 36'sd0);
  assign mix_l = sum_l[31:16];
  assign mix_r = sum_r[31:16];

  assign rel_fire = check_r && !rel_valid_r
                  && (loop_end_r == '0 || trim_end_r < loop_end_r)
                  && ({1'b0, p_r} + 26'(margin_r) > 26'(trim_end_r));

  slp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  slp_ram #(
    .WIDTH (SMP_W),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_sample_address),
    .wdata (in_sample_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_start_r <= '0;
      loop_end_r   <= '0;
      trim_start_r <= '0;
      trim_end_r   <= 16'hFFFF;
      margin_r     <= '0;
      slen_r       <= '0;
      ramp_r       <= '0;
      format_r     <= 6'd61;
      state_r      <= S_IDLE;
      rel_valid_r  <= 1'b0;
      rel_step_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_LOOP_START: loop_start_r <= cfg_data[15:0];
          REG_LOOP_END:   loop_end_r   <= cfg_data[15:0];
          REG_TRIM_START: trim_start_r <= cfg_data[15:0];
          REG_TRIM_END:   trim_end_r   <= cfg_data[15:0];
          REG_REL_MARGIN: margin_r     <= cfg_data[15:0];
          REG_SAMPLE_LEN: slen_r       <= cfg_data;
          REG_LOOP_RAMP:  ramp_r       <= cfg_data[7:0];
          REG_FORMAT:     format_r     <= cfg_data[5:0];
          default:        format_r     <= format_r;
        endcase
      end
      if (accept && in_action == ACT_RESTART) begin
        rel_valid_r <= 1'b0;
        rel_step_r  <= '0;
      end
      if (state_r == S_FIN && fin_go && rel_fire) begin
        rel_valid_r <= 1'b1;
        rel_step_r  <= step_r;
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == S_FIN && fin_go) out_valid_r <= 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        do_read_r <= 1'b0;
        do_mix_r  <= 1'b0;
        check_r   <= 1'b0;
        idx_r     <= '0;
        k_r       <= '0;
        step_r    <= in_step_count;
        p_r       <= POS_W'(in_pitched_position) + POS_W'(trim_start_r)
                   + POS_W'(in_position_offset);
      end
      S_PLAN: begin
        check_r   <= !(loop_end_r != '0 && loop_start_r >= loop_end_r && p_gt_le);
        do_read_r <= (loop_end_r == '0)
                   ? (loop_start_r == '0 && p_r < POS_W'(slen_r))
                   : !(loop_start_r >= loop_end_r && p_gt_le);
        rmn_r     <= rm_num;
      end
      S_DPP: if (drsp.done) begin
        // Even pass count runs backward from the loop end.
        p_r <= drsp.quot[0] ? POS_W'(loop_start_r) + POS_W'(drsp.rem)
                            : POS_W'(loop_end_r) - POS_W'(drsp.rem);
      end
      S_DRM: begin
        rm_r <= rm_calc;
        ll_r <= ll_new;
      end
      S_DLL: if (drsp.done) begin
        p_r <= POS_W'(loop_start_r) + POS_W'(rm_r) + POS_W'(drsp.rem);
      end
      S_XF: do_mix_r <= xf_hit;
      S_DW: if (drsp.done) w_r <= drsp.quot[16:0];
      S_RA: oor_r <= ({1'b0, frame} >= MAXF) || (addr26 >= 26'(MEM_DEPTH));
      S_RD: begin
        word_r[idx_r] <= oor_r ? 16'h0000 : (ram_rdata & qmask);
        idx_r <= idx_r + 2'd1;
      end
      S_MIX: begin
        if (k_r < 3'd4) prod_r <= 36'(mul_a * mul_b);
        case (k_r)
          3'd1: accl_r <= prod_r;
          3'd2: accl_r <= accl_r + prod_r;
          3'd3: accr_r <= prod_r;
          3'd4: accr_r <= accr_r + prod_r;
          default: accr_r <= accr_r;
        endcase
        k_r <= k_r + 3'd1;
      end
      S_FIN: if (fin_go) begin
        out_l_r    <= !do_read_r ? 16'h0000 : (do_mix_r ? mix_l : word_r[0]);
        out_r_r    <= !do_read_r ? 16'h0000 : (do_mix_r ? mix_r : word_r[1]);
        out_rel_r  <= rel_valid_r || rel_fire;
        out_step_r <= rel_fire ? step_r : rel_step_r;
      end
      default: oor_r <= oor_r;
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_left_out          = out_l_r;
  assign out_right_out         = out_r_r;
  assign out_release_triggered = out_rel_r;
  assign out_release_step      = out_step_r;

endmodule
